// ===== hw/rtl/rth_pkg.sv =====
// shared types, widths and register codes for the ray-triangle hit test
package rth_pkg;

	localparam int COORD_BITS = 16;
	localparam int EPS_W = 48;
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = EPS_W;
	localparam int IN_TDATA_W = ((9 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;

	// register stages in the hit test pipeline
	localparam int NSTG = 7;

	// differences of two coordinates
	localparam int DIFF_W = COORD_BITS + 1;
	// one product inside a cross product
	localparam int PROD_W = 2 * DIFF_W;
	// one component of a cross product
	localparam int CR_W = PROD_W + 1;
	// one product inside a dot product
	localparam int DP_W = DIFF_W + CR_W;
	// dot product sum
	localparam int DOT_W = DP_W + 2;
	// u + v
	localparam int SUM_W = DOT_W + 1;
	// common width for the final compares, sign bit included
	localparam int CMP_W = ((SUM_W > EPS_W) ? SUM_W : EPS_W) + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [CR_W-1:0] cross_t;
	typedef logic signed [DP_W-1:0] dprod_t;
	typedef logic signed [DOT_W-1:0] dot_t;
	typedef logic [EPS_W-1:0] eps_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5,
		REG_EPSILON  = 3'd6
	} reg_idx_t;

	localparam coord_t DIR_Z_RESET = coord_t'(256);
	localparam eps_t EPS_RESET = eps_t'(1678);

	typedef struct packed {
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t dir_x;
		coord_t dir_y;
		coord_t dir_z;
		eps_t   epsilon;
	} ray_cfg_t;

endpackage

// ===== hw/rtl/ray_triangle_hit_test.sv =====
// an accepted triangle moves through the seven register stages to its hit flag on the master side
// throughput: one triangle per cycle while m_tready stays high; each stage holds its item only while the one
// after it is full and cannot move, so a stall fills bubbles before it stops input
// the hit test runs in a seven-stage multiply and compare pipeline
// reset clears all stage valid bits and loads the ray registers with their reset values
module ray_triangle_hit_test (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
	// vertex2_x, vertex2_y, vertex2_z from the lowest bit up
	input  logic [rth_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// hit, then zero padding
	output logic [rth_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rth_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [rth_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rth_pkg::*;

	ray_cfg_t cfg;
	coord_t   org [3];
	coord_t   dir [3];
	diff_t    dir_d [3];
	coord_t   vtx [9];

	logic [1:NSTG]   vld_q;
	logic [1:NSTG+1] ld;

	diff_t  e1_s1 [3];
	diff_t  e2_s1 [3];
	diff_t  t_s1 [3];

	prod_t  pa_s2 [3];
	prod_t  pb_s2 [3];
	prod_t  qa_s2 [3];
	prod_t  qb_s2 [3];
	diff_t  e1_s2 [3];
	diff_t  t_s2 [3];

	cross_t p_s3 [3];
	cross_t q_s3 [3];
	diff_t  e1_s3 [3];
	diff_t  t_s3 [3];

	dprod_t dp_s4 [3];
	dprod_t up_s4 [3];
	dprod_t vp_s4 [3];

	dot_t   det_s5;
	dot_t   u_s5;
	dot_t   v_s5;

	dot_t   det_s6;
	dot_t   u_s6;
	dot_t   v_s6;

	logic   hit_s7;

	logic signed [CMP_W-1:0] det_c;
	logic signed [CMP_W-1:0] u_c;
	logic signed [CMP_W-1:0] v_c;
	logic signed [CMP_W-1:0] uv_c;
	logic signed [CMP_W-1:0] eps_c;
	logic                    flip;

	rth_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign org[0] = cfg.origin_x;
	assign org[1] = cfg.origin_y;
	assign org[2] = cfg.origin_z;
	assign dir[0] = cfg.dir_x;
	assign dir[1] = cfg.dir_y;
	assign dir[2] = cfg.dir_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dir_d[i] = DIFF_W'(dir[i]);
		end
		for (int i = 0; i < 9; i++) begin
			vtx[i] = coord_t'(s_tdata[i*COORD_BITS +: COORD_BITS]);
		end
	end

	// a stage loads when it is empty or its contents move on this cycle
	always_comb begin
		ld[NSTG+1] = m_tready;
		for (int k = NSTG; k >= 1; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	assign s_tready = ld[1];
	assign m_tvalid = vld_q[NSTG];
	assign m_tdata = {(OUT_TDATA_W-1)'(0), hit_s7};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: edges and origin offset
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= DIFF_W'(vtx[3+i]) - DIFF_W'(vtx[i]);
				e2_s1[i] <= DIFF_W'(vtx[6+i]) - DIFF_W'(vtx[i]);
				t_s1[i] <= DIFF_W'(org[i]) - DIFF_W'(vtx[i]);
			end
		end
	end

	// stage 2: products for P = dir x E2 and Q = T x E1
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			pa_s2[0] <= PROD_W'(dir_d[1]) * PROD_W'(e2_s1[2]);
			pb_s2[0] <= PROD_W'(dir_d[2]) * PROD_W'(e2_s1[1]);
			pa_s2[1] <= PROD_W'(dir_d[2]) * PROD_W'(e2_s1[0]);
			pb_s2[1] <= PROD_W'(dir_d[0]) * PROD_W'(e2_s1[2]);
			pa_s2[2] <= PROD_W'(dir_d[0]) * PROD_W'(e2_s1[1]);
			pb_s2[2] <= PROD_W'(dir_d[1]) * PROD_W'(e2_s1[0]);
			qa_s2[0] <= PROD_W'(t_s1[1]) * PROD_W'(e1_s1[2]);
			qb_s2[0] <= PROD_W'(t_s1[2]) * PROD_W'(e1_s1[1]);
			qa_s2[1] <= PROD_W'(t_s1[2]) * PROD_W'(e1_s1[0]);
			qb_s2[1] <= PROD_W'(t_s1[0]) * PROD_W'(e1_s1[2]);
			qa_s2[2] <= PROD_W'(t_s1[0]) * PROD_W'(e1_s1[1]);
			qb_s2[2] <= PROD_W'(t_s1[1]) * PROD_W'(e1_s1[0]);
			e1_s2 <= e1_s1;
			t_s2 <= t_s1;
		end
	end

	// stage 3: cross product components
	always_ff @(posedge clk) begin
		if (ld[3]) begin
			for (int i = 0; i < 3; i++) begin
				p_s3[i] <= CR_W'(pa_s2[i]) - CR_W'(pb_s2[i]);
				q_s3[i] <= CR_W'(qa_s2[i]) - CR_W'(qb_s2[i]);
			end
			e1_s3 <= e1_s2;
			t_s3 <= t_s2;
		end
	end

	// stage 4: dot product terms for det, u and v
	always_ff @(posedge clk) begin
		if (ld[4]) begin
			for (int i = 0; i < 3; i++) begin
				dp_s4[i] <= DP_W'(e1_s3[i]) * DP_W'(p_s3[i]);
				up_s4[i] <= DP_W'(t_s3[i]) * DP_W'(p_s3[i]);
				vp_s4[i] <= DP_W'(dir_d[i]) * DP_W'(q_s3[i]);
			end
		end
	end

	// stage 5: dot product sums
	always_ff @(posedge clk) begin
		if (ld[5]) begin
			det_s5 <= DOT_W'(dp_s4[0]) + DOT_W'(dp_s4[1]) + DOT_W'(dp_s4[2]);
			u_s5 <= DOT_W'(up_s4[0]) + DOT_W'(up_s4[1]) + DOT_W'(up_s4[2]);
			v_s5 <= DOT_W'(vp_s4[0]) + DOT_W'(vp_s4[1]) + DOT_W'(vp_s4[2]);
		end
	end

	// stage 6: a non-positive det flips T, which negates u and v along with det
	assign flip = !(det_s5 > dot_t'(0));

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			det_s6 <= flip ? -det_s5 : det_s5;
			u_s6 <= flip ? -u_s5 : u_s5;
			v_s6 <= flip ? -v_s5 : v_s5;
		end
	end

	// stage 7: range checks
	always_comb begin
		det_c = CMP_W'(det_s6);
		u_c = CMP_W'(u_s6);
		v_c = CMP_W'(v_s6);
		uv_c = CMP_W'(u_s6) + CMP_W'(v_s6);
		eps_c = $signed({(CMP_W-EPS_W)'(0), cfg.epsilon});
	end

	always_ff @(posedge clk) begin
		if (ld[7]) begin
			hit_s7 <= !(det_c < eps_c) && !(u_c < 0) && !(u_c > det_c)
				&& !(v_c < 0) && !(uv_c > det_c);
		end
	end

endmodule

// ===== hw/rtl/rth_cfg_regs.sv =====
// configuration registers holding the ray and the determinant threshold
module rth_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rth_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [rth_pkg::CFG_DATA_W-1:0] cfg_data,
	output rth_pkg::ray_cfg_t             cfg
);
	import rth_pkg::*;

	ray_cfg_t cfg_q;
	coord_t   wr_coord;

	assign cfg_ready = 1'b1;
	assign wr_coord = coord_t'(cfg_data[COORD_BITS-1:0]);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.origin_z <= '0;
			cfg_q.dir_x <= '0;
			cfg_q.dir_y <= '0;
			cfg_q.dir_z <= DIR_Z_RESET;
			cfg_q.epsilon <= EPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			// an index past the list is dropped
			unique case (reg_idx_t'(cfg_index))
				REG_ORIGIN_X: cfg_q.origin_x <= wr_coord;
				REG_ORIGIN_Y: cfg_q.origin_y <= wr_coord;
				REG_ORIGIN_Z: cfg_q.origin_z <= wr_coord;
				REG_DIR_X:    cfg_q.dir_x <= wr_coord;
				REG_DIR_Y:    cfg_q.dir_y <= wr_coord;
				REG_DIR_Z:    cfg_q.dir_z <= wr_coord;
				REG_EPSILON:  cfg_q.epsilon <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

endmodule
